[src/dsort_pkg.sv]
// Package for the descending index sort core: sizes, payload types and the
// command and status structs passed between controller and datapath.
// No dependencies.
package dsort_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int KEY_BITS    = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int KEY_FIELD_W = 16;
  localparam int IDX_FIELD_W = 6;

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // store the incoming word (or mark it dropped)
    logic sort;   // perform one compare-exchange round
    logic phase;  // 0: even pairs, 1: odd pairs
    logic shift;  // head entry taken, advance the row
  } dsort_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_entry;  // exactly one stored entry remains
  } dsort_sts_t;

endpackage

[src/dsort_ctrl.sv]
// Controller for the descending index sort core: load, sort and emit phases.
// Depends on dsort_pkg.
module dsort_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  last_key_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output dsort_pkg::dsort_cmd_t cmd_o,
  input  dsort_pkg::dsort_sts_t sts_i
);

  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_SORT = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  localparam dsort_pkg::idx_t LastRound = dsort_pkg::IDX_W'(dsort_pkg::MAX_ENTRIES - 1);

  state_e          state_q, state_d;
  dsort_pkg::idx_t round_q, round_d;

  always_comb begin
    state_d     = state_q;
    round_d     = round_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (last_key_i) begin
            state_d = ST_SORT;
            round_d = '0;
          end
        end
      end
      ST_SORT: begin
        cmd_o.sort  = 1'b1;
        cmd_o.phase = round_q[0];
        round_d     = round_q + 1'b1;
        if (round_q == LastRound) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.shift = 1'b1;
          if (sts_i.last_entry) begin
            state_d = ST_LOAD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      round_q <= '0;
    end else begin
      state_q <= state_d;
      round_q <= round_d;
    end
  end

endmodule

[src/dsort_dp.sv]
// Datapath for the descending index sort core: a row of key and index
// registers with compare-exchange cells, fill count and drop flag.
// Depends on dsort_pkg.
module dsort_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  dsort_pkg::dsort_cmd_t                  cmd_i,
  output dsort_pkg::dsort_sts_t                  sts_o,
  input  logic [dsort_pkg::KEY_FIELD_W-1:0]      sel_key_i,
  output logic [dsort_pkg::IDX_FIELD_W-1:0]      entry_index_o,
  output logic [dsort_pkg::KEY_FIELD_W-1:0]      entry_key_o,
  output logic                                   last_out_o,
  output logic                                   overflow_flag_o
);

  localparam dsort_pkg::cnt_t Capacity = dsort_pkg::CNT_W'(dsort_pkg::MAX_ENTRIES);

  dsort_pkg::key_t key_q [dsort_pkg::MAX_ENTRIES];
  dsort_pkg::key_t key_d [dsort_pkg::MAX_ENTRIES];
  dsort_pkg::idx_t idx_q [dsort_pkg::MAX_ENTRIES];
  dsort_pkg::idx_t idx_d [dsort_pkg::MAX_ENTRIES];
  dsort_pkg::cnt_t fill_q, fill_d;
  logic            drop_q, drop_d;

  always_comb begin
    key_d  = key_q;
    idx_d  = idx_q;
    fill_d = fill_q;
    drop_d = drop_q;
    if (cmd_i.load) begin
      if (fill_q < Capacity) begin
        key_d[fill_q[dsort_pkg::IDX_W-1:0]] = dsort_pkg::key_t'(sel_key_i);
        idx_d[fill_q[dsort_pkg::IDX_W-1:0]] = fill_q[dsort_pkg::IDX_W-1:0];
        fill_d = fill_q + 1'b1;
      end else begin
        drop_d = 1'b1;
      end
    end
    if (cmd_i.sort) begin
      // Each cell exchanges only on a strictly larger upper key, which
      // keeps entries with equal keys in their entry order.
      for (int p = 0; p < dsort_pkg::MAX_ENTRIES - 1; p++) begin
        if (((p % 2) == int'(cmd_i.phase)) &&
            (dsort_pkg::CNT_W'(p + 1) < fill_q) &&
            (key_q[p] < key_q[p+1])) begin
          key_d[p]   = key_q[p+1];
          key_d[p+1] = key_q[p];
          idx_d[p]   = idx_q[p+1];
          idx_d[p+1] = idx_q[p];
        end
      end
    end
    if (cmd_i.shift) begin
      for (int i = 0; i < dsort_pkg::MAX_ENTRIES - 1; i++) begin
        key_d[i] = key_q[i+1];
        idx_d[i] = idx_q[i+1];
      end
      fill_d = fill_q - 1'b1;
      if (fill_q == dsort_pkg::CNT_W'(1)) begin
        drop_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    idx_q <= idx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      drop_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      drop_q <= drop_d;
    end
  end

  assign sts_o.last_entry = (fill_q == dsort_pkg::CNT_W'(1));
  assign entry_index_o    = dsort_pkg::IDX_FIELD_W'(idx_q[0]);
  assign entry_key_o      = dsort_pkg::KEY_FIELD_W'(key_q[0]);
  assign last_out_o       = sts_o.last_entry;
  assign overflow_flag_o  = drop_q;

endmodule

[src/descending_index_sort_core.sv]
// Top level of the descending index sort core: joins controller and datapath.
// Depends on dsort_pkg, dsort_ctrl and dsort_dp.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-------------------------------------
//   input   | in        | in_valid_i / in_ready_o | sel_key_i, last_key_i
//   output  | out       | out_valid_o/out_ready_i | entry_index_o, entry_key_o,
//           |           |                         | last_out_o, overflow_flag_o
//
// A set of keys is loaded one word per cycle while in_valid_i is high, then
// MAX_ENTRIES odd-even compare-exchange rounds run over the register row,
// then the stored words are emitted, one word per cycle while out_ready_i is high.
// The sort length is set by the number of rounds the row needs in the worst case.
// Input is only taken while loading and output only offered while emitting, so
// a stall on the output holds the whole block. Reset clears the state machine,
// the fill count and the drop flag; the key row needs no reset.
//
// Keys are kept in entry order in the row; each round compares neighbouring
// pairs among the filled positions and exchanges them when the upper key is
// strictly larger, so equal keys keep their entry order. Keys arriving once the
// row is full are dropped and reported on every word of that run.
module descending_index_sort_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [dsort_pkg::KEY_FIELD_W-1:0]     sel_key_i,
  input  logic                                  last_key_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [dsort_pkg::IDX_FIELD_W-1:0]     entry_index_o,
  output logic [dsort_pkg::KEY_FIELD_W-1:0]     entry_key_o,
  output logic                                  last_out_o,
  output logic                                  overflow_flag_o
);

  dsort_pkg::dsort_cmd_t cmd;
  dsort_pkg::dsort_sts_t sts;

  dsort_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_key_i  (last_key_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  dsort_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .sel_key_i       (sel_key_i),
    .entry_index_o   (entry_index_o),
    .entry_key_o     (entry_key_o),
    .last_out_o      (last_out_o),
    .overflow_flag_o (overflow_flag_o)
  );

endmodule

[src/dsort_checker.sv]
// Port-level checks for the descending index sort core, bound to the top level.
// Depends on dsort_pkg and descending_index_sort_core.
module dsort_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              last_key_i,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [dsort_pkg::IDX_FIELD_W-1:0] entry_index_o,
  input logic [dsort_pkg::KEY_FIELD_W-1:0] entry_key_o,
  input logic                              last_out_o,
  input logic                              overflow_flag_o
);

  // The block never loads and emits in the same cycle.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while output valid");

  // An accepted final key starts the sort, so no further word is taken.
  a_sort_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && last_key_i) |=> !in_ready_o)
    else $error("input ready right after final key");

  // After the final word of a run the block returns to loading.
  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_out_o) |=> (!out_valid_o && in_ready_o))
    else $error("block did not return to loading after run");

  // The overflow flag is the same on every word of a run.
  a_flag_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_out_o) |=> $stable(overflow_flag_o))
    else $error("overflow flag changed within a run");

  // A stalled output word stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(entry_index_o) && $stable(entry_key_o)))
    else $error("output word withdrawn while stalled");

endmodule

bind descending_index_sort_core dsort_checker u_dsort_checker (.*);

[test/descending_index_sort_core_tb.sv]
// Self-checking testbench for descending_index_sort_core: drives key sets and predicts the
// sorted runs, checking each output word against a small scoreboard.
// Depends on dsort_pkg and the descending_index_sort_core RTL.
module descending_index_sort_core_tb;

  // One expected output word of a sorted run.
  typedef struct packed {
    logic [dsort_pkg::IDX_FIELD_W-1:0] index;
    logic [dsort_pkg::KEY_FIELD_W-1:0] key;
    logic                              last;
    logic                              ovf;
  } rank_word_t;

  // Holds the keys of the set being loaded and the ranked words still owed by the block.
  class rank_board;
    dsort_pkg::key_t key_row[$];
    bit              dropped;
    rank_word_t      ranks_due[$];
    int unsigned     faults;

    // Record an accepted input word. When it closes the set, rank the stored keys into
    // descending order; earlier entries stay ahead of later ones with an equal key.
    function void note_key(logic [dsort_pkg::KEY_FIELD_W-1:0] word_key, logic word_last);
      int         order[$];
      int         pos;
      rank_word_t w;
      if (key_row.size() < dsort_pkg::MAX_ENTRIES)
        key_row.push_back(dsort_pkg::key_t'(word_key));
      else dropped = 1'b1;
      if (!word_last) return;
      for (int i = 0; i < key_row.size(); i++) begin
        pos = order.size();
        while (pos > 0 && key_row[order[pos-1]] < key_row[i]) pos--;
        order.insert(pos, i);
      end
      for (int k = 0; k < order.size(); k++) begin
        w.index = dsort_pkg::IDX_FIELD_W'(order[k]);
        w.key   = dsort_pkg::KEY_FIELD_W'(key_row[order[k]]);
        w.last  = (k == order.size() - 1);
        w.ovf   = dropped;
        ranks_due.push_back(w);
      end
      key_row.delete();
      dropped = 1'b0;
    endfunction

    function void complain(string what, rank_word_t want, rank_word_t got);
      faults++;
      if (faults <= 10)
        $display("%s: expected index %0d key %h last %b ovf %b, %s %0d key %h last %b ovf %b",
                 what, want.index, want.key, want.last, want.ovf, "got index",
                 got.index, got.key, got.last, got.ovf);
    endfunction

    // Compare an accepted output word, field by field, with the oldest expectation.
    function void check_word(rank_word_t got);
      rank_word_t want;
      if (ranks_due.size() == 0) begin
        complain("Unexpected word", '0, got);
        return;
      end
      want = ranks_due.pop_front();
      if (want.index !== got.index || want.key !== got.key ||
          want.last !== got.last || want.ovf !== got.ovf)
        complain("Mismatch", want, got);
    endfunction

    function int pending();
      return ranks_due.size();
    endfunction
  endclass

  logic                              clk_i;
  logic                              rst_ni;
  logic                              in_valid_i;
  logic                              in_ready_o;
  logic [dsort_pkg::KEY_FIELD_W-1:0] sel_key_i;
  logic                              last_key_i;
  logic                              out_valid_o;
  logic                              out_ready_i;
  logic [dsort_pkg::IDX_FIELD_W-1:0] entry_index_o;
  logic [dsort_pkg::KEY_FIELD_W-1:0] entry_key_o;
  logic                              last_out_o;
  logic                              overflow_flag_o;

  rank_board board;
  bit        calm;        // set for the closing stretch, where neither side idles
  int        items_sent;

  descending_index_sort_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sel_key_i      (sel_key_i),
    .last_key_i     (last_key_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .entry_index_o  (entry_index_o),
    .entry_key_o    (entry_key_o),
    .last_out_o     (last_out_o),
    .overflow_flag_o(overflow_flag_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // The whole run ends here if the block stops making progress.
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Offer one input word from a falling edge and hold it until it is accepted. An idle burst
  // may come first; valid is only lowered there, so it is never lowered and raised in one step.
  task automatic send_word(input logic [dsort_pkg::KEY_FIELD_W-1:0] word_key,
                           input logic word_last);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sel_key_i  <= word_key;
    last_key_i <= word_last;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_key(word_key, word_last);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Keys are drawn from the whole range, from a tiny range that forces ties, or from the
  // extremes, single-bit values and their complements.
  function automatic logic [dsort_pkg::KEY_FIELD_W-1:0] pick_key(int flavour);
    case (flavour)
      0:       return dsort_pkg::KEY_FIELD_W'($urandom_range(0, 16'hFFFF));
      1:       return dsort_pkg::KEY_FIELD_W'($urandom_range(0, 3));
      default: begin
        case ($urandom_range(0, 3))
          0:       return '0;
          1:       return '1;
          2:       return dsort_pkg::KEY_FIELD_W'(1)
                          << $urandom_range(0, dsort_pkg::KEY_FIELD_W - 1);
          default: return ~(dsort_pkg::KEY_FIELD_W'(1)
                            << $urandom_range(0, dsort_pkg::KEY_FIELD_W - 1));
        endcase
      end
    endcase
  endfunction

  task automatic send_random_set(input int count, input int flavour);
    for (int i = 0; i < count; i++) send_word(pick_key(flavour), i == count - 1);
  endtask

  // Receiver: ready is changed at falling edges, stalling in random bursts until the
  // closing stretch.
  initial begin
    int stall_left;
    out_ready_i = 1'b0;
    stall_left  = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        stall_left  = $urandom_range(1, 13) - 1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Output words are taken at the rising edge, before any register update of that edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_word('{entry_index_o, entry_key_o, last_out_o, overflow_flag_o});
  end

  initial begin
    int count;
    int pick;
    board      = new();
    calm       = 1'b0;
    items_sent = 0;
    in_valid_i = 1'b0;
    sel_key_i  = '0;
    last_key_i = 1'b0;
    rst_ni     = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Single-word sets at both key extremes.
    send_word(16'h0000, 1'b1);
    send_word(16'hFFFF, 1'b1);
    // Equal keys must come out in entry order.
    send_word(16'h0005, 1'b0);
    send_word(16'h0005, 1'b0);
    send_word(16'h0005, 1'b1);
    // Ascending keys, so every pair has to be exchanged.
    for (int i = 0; i < 4; i++) send_word(dsort_pkg::KEY_FIELD_W'(i + 1), i == 3);
    // A full row followed by a last word that no longer fits: it is dropped but still
    // closes the set, and the whole run reports the overflow.
    for (int i = 0; i < dsort_pkg::MAX_ENTRIES; i++)
      send_word(dsort_pkg::KEY_FIELD_W'((i % 3 == 0) ? 32'hFFFF :
                                        (i % 3 == 1) ? 32'h0000 : (32'hA5A5 ^ i)), 1'b0);
    send_word(16'h1234, 1'b1);

    // Hold the sender back until the block has emitted everything owed so far.
    while (board.pending() != 0) @(negedge clk_i);

    while (items_sent < 110) begin
      calm = (items_sent >= 88);
      pick = $urandom_range(0, 9);
      if (pick == 0)     count = $urandom_range(dsort_pkg::MAX_ENTRIES + 1,
                                                dsort_pkg::MAX_ENTRIES + 4);
      else if (pick < 3) count = $urandom_range(1, 3);
      else               count = $urandom_range(4, dsort_pkg::MAX_ENTRIES);
      send_random_set(count, $urandom_range(0, 2));
    end
    in_valid_i <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    // Allow a spell for any stray word to show up after the last expected one.
    repeat (60) @(posedge clk_i);
    board.faults += board.pending();
    if (board.faults == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
